>>> sv/fdly_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdly_pkg
// Shared types and constants of the two-tap feedback delay: register map,
// field widths, reset values of the configuration registers.
// ----------------------------------------------------------------------------
package fdly_pkg;

  localparam int RING_DEPTH_DEF  = 262144;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int DELAY_W    = 18;
  localparam int GAIN_W     = 16;
  localparam int COEF_W     = 16;
  localparam int FILT_W     = 32;
  // multiplier coefficient operand: Q1.15 gain up to unity, or sign-extended Q2.14
  localparam int OPB_W      = 17;

  localparam logic [OPB_W-1:0] UNITY = 17'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_DELAY   = 3'd0,
    REG_TAP_DELAY     = 3'd1,
    REG_FEEDBACK_GAIN = 3'd2,
    REG_WET_DRY       = 3'd3,
    REG_TAP_MIX       = 3'd4,
    REG_COEF_B0       = 3'd5,
    REG_COEF_B1       = 3'd6,
    REG_COEF_A1       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        [DELAY_W-1:0] total_delay;
    logic        [DELAY_W-1:0] tap_delay;
    logic        [GAIN_W-1:0]  feedback_gain;
    logic        [GAIN_W-1:0]  wet_dry;
    logic        [GAIN_W-1:0]  tap_mix;
    logic signed [COEF_W-1:0]  coef_b0;
    logic signed [COEF_W-1:0]  coef_b1;
    logic signed [COEF_W-1:0]  coef_a1;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    total_delay:   18'd72000,
    tap_delay:     18'd36000,
    feedback_gain: 16'd16384,
    wet_dry:       16'd16384,
    tap_mix:       16'd16384,
    coef_b0:       16'sd1907,
    coef_b1:       16'sd1907,
    coef_a1:       -16'sd12571
  };

endpackage : fdly_pkg
`default_nettype wire

>>> sv/fdly_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdly_ring
// Single-port delay line memory: one write or one read per cycle, read data
// registered.
// ----------------------------------------------------------------------------
module fdly_ring #(
  parameter int DEPTH  = 262144,
  parameter int DATA_W = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : fdly_ring
`default_nettype wire

>>> sv/fdly_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdly_core
// Sample sequencer: one shared multiplier steps through feedback, both tap
// lowpass filters, tap crossfade and wet/dry blend; drives the ring port
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module fdly_core
  import fdly_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          run_i,
  input  wire cfg_t                          cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_o,
  output logic                               ring_we_o,
  output logic [$clog2(RING_DEPTH)-1:0]      ring_addr_o,
  output logic [SAMPLE_BITS-1:0]             ring_wdata_o,
  input  wire logic [SAMPLE_BITS-1:0]        ring_rdata_i
);

  localparam int SW     = SAMPLE_BITS;
  localparam int ADDR_W = $clog2(RING_DEPTH);
  localparam int P_W    = SW + OPB_W;
  localparam int WIDE_W = (SW + 19 > FILT_W + 2) ? SW + 19 : FILT_W + 2;

  localparam logic signed [WIDE_W-1:0] S_MAX = {{(WIDE_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] S_MIN = {{(WIDE_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [WIDE_W-1:0] F_MAX =
    {{(WIDE_W-FILT_W+1){1'b0}}, {(FILT_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] F_MIN =
    {{(WIDE_W-FILT_W+1){1'b1}}, {(FILT_W-1){1'b0}}};

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_FB   = 15'h0002,
    S_RDM  = 15'h0004,
    S_RDT  = 15'h0008,
    S_YM   = 15'h0010,
    S_SM1  = 15'h0020,
    S_SM2  = 15'h0040,
    S_YT   = 15'h0080,
    S_ST1  = 15'h0100,
    S_ST2  = 15'h0200,
    S_MX1  = 15'h0400,
    S_MX2  = 15'h0800,
    S_WD   = 15'h1000,
    S_WX1  = 15'h2000,
    S_OUT  = 15'h4000
  } seq_state_e;

  function automatic logic signed [WIDE_W-1:0] rnd_sh(
    input logic signed [WIDE_W-1:0] v,
    input int unsigned              sh
  );
    logic signed [WIDE_W-1:0] half;
    logic signed [WIDE_W-1:0] t;
    half = WIDE_W'(1) << (sh - 1);
    t    = v + half;
    return t >>> sh;
  endfunction

  function automatic logic signed [SW-1:0] sat_s(input logic signed [WIDE_W-1:0] v);
    logic signed [SW-1:0] r;
    if (v > S_MAX) begin
      r = S_MAX[SW-1:0];
    end else if (v < S_MIN) begin
      r = S_MIN[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [FILT_W-1:0] sat_f(input logic signed [WIDE_W-1:0] v);
    logic signed [FILT_W-1:0] r;
    if (v > F_MAX) begin
      r = F_MAX[FILT_W-1:0];
    end else if (v < F_MIN) begin
      r = F_MIN[FILT_W-1:0];
    end else begin
      r = v[FILT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [OPB_W-1:0] gain_lim(input logic [GAIN_W-1:0] g);
    logic [OPB_W-1:0] ge;
    ge = {1'b0, g};
    return (ge > UNITY) ? UNITY : ge;
  endfunction

  seq_state_e state_q, state_d;

  logic [ADDR_W-1:0]            wi_q;
  logic signed [SW-1:0]         last_q, last_d;
  logic signed [FILT_W-1:0]     sm_q, sm_d, st_q, st_d;
  logic                         out_valid_q, out_valid_d;
  logic signed [SW-1:0]         out_q;
  logic signed [SW-1:0]         x_q, tm_q, tt_q, ym_q, yt_q;
  logic signed [P_W-1:0]        p_q;
  logic signed [WIDE_W-1:0]     acc_q;

  logic signed [SW-1:0]         mul_a;
  logic signed [OPB_W-1:0]      mul_b;
  logic signed [P_W-1:0]        prod;
  logic signed [WIDE_W-1:0]     p_wide;
  logic signed [SW-1:0]         w_val, ym_val, yt_val, d_val, o_val;
  logic signed [FILT_W-1:0]     s_val;

  logic [OPB_W-1:0]             fb_g, wet_g, mix_g, wet_c, mix_c;
  logic signed [OPB_W-1:0]      b0_op, b1_op, a1_op;
  logic [ADDR_W-1:0]            rd_main, rd_tap;
  logic                         accept, out_load;

  assign fb_g  = gain_lim(cfg_i.feedback_gain);
  assign wet_g = gain_lim(cfg_i.wet_dry);
  assign mix_g = gain_lim(cfg_i.tap_mix);
  assign wet_c = UNITY - wet_g;
  assign mix_c = UNITY - mix_g;
  assign b0_op = {cfg_i.coef_b0[COEF_W-1], cfg_i.coef_b0};
  assign b1_op = {cfg_i.coef_b1[COEF_W-1], cfg_i.coef_b1};
  assign a1_op = {cfg_i.coef_a1[COEF_W-1], cfg_i.coef_a1};

  // delays wrap modulo 2**ADDR_W, the ring depth when that is a power of two
  assign rd_main = wi_q - ADDR_W'(cfg_i.total_delay);
  assign rd_tap  = wi_q - ADDR_W'(cfg_i.tap_delay);

  assign in_ready_o = (state_q == S_IDLE) && run_i;
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign p_wide = WIDE_W'(p_q);
  assign w_val  = sat_s(WIDE_W'(x_q) + rnd_sh(p_wide, 15));
  assign ym_val = sat_s(rnd_sh(p_wide, 14) + WIDE_W'(sm_q));
  assign yt_val = sat_s(rnd_sh(p_wide, 14) + WIDE_W'(st_q));
  assign s_val  = sat_f(rnd_sh(acc_q - p_wide, 14));
  assign d_val  = sat_s(rnd_sh(acc_q + p_wide, 15));
  assign o_val  = d_val;

  // operand select of the shared multiplier
  always_comb begin
    mul_a = x_q;
    mul_b = $signed(wet_c);
    case (state_q)
      S_IDLE: begin
        mul_a = last_q;
        mul_b = $signed(fb_g);
      end
      S_RDT: begin
        mul_a = $signed(ring_rdata_i);
        mul_b = b0_op;
      end
      S_YM: begin
        mul_a = tm_q;
        mul_b = b1_op;
      end
      S_SM1: begin
        mul_a = ym_q;
        mul_b = a1_op;
      end
      S_SM2: begin
        mul_a = tt_q;
        mul_b = b0_op;
      end
      S_YT: begin
        mul_a = tt_q;
        mul_b = b1_op;
      end
      S_ST1: begin
        mul_a = yt_q;
        mul_b = a1_op;
      end
      S_ST2: begin
        mul_a = ym_q;
        mul_b = $signed(mix_c);
      end
      S_MX1: begin
        mul_a = yt_q;
        mul_b = $signed(mix_g);
      end
      S_WD: begin
        mul_a = last_q;
        mul_b = $signed(wet_g);
      end
      default: begin
        mul_a = x_q;
        mul_b = $signed(wet_c);
      end
    endcase
  end

  assign prod = P_W'(mul_a) * P_W'(mul_b);

  // ring port: write the feedback sum, then read main and second tap
  always_comb begin
    ring_we_o    = 1'b0;
    ring_addr_o  = wi_q;
    ring_wdata_o = w_val;
    case (state_q)
      S_FB:    ring_we_o   = 1'b1;
      S_RDM:   ring_addr_o = rd_main;
      S_RDT:   ring_addr_o = rd_tap;
      default: ring_addr_o = wi_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    sm_d        = sm_q;
    st_d        = st_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE:  if (accept) state_d = S_FB;
      S_FB:    state_d = S_RDM;
      S_RDM:   state_d = S_RDT;
      S_RDT:   state_d = S_YM;
      S_YM:    state_d = S_SM1;
      S_SM1:   state_d = S_SM2;
      S_SM2: begin
        sm_d    = s_val;
        state_d = S_YT;
      end
      S_YT:    state_d = S_ST1;
      S_ST1:   state_d = S_ST2;
      S_ST2: begin
        st_d    = s_val;
        state_d = S_MX1;
      end
      S_MX1:   state_d = S_MX2;
      S_MX2: begin
        last_d  = d_val;
        state_d = S_WD;
      end
      S_WD:    state_d = S_WX1;
      S_WX1:   state_d = S_OUT;
      S_OUT: begin
        // hold until the output register is free
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wi_q        <= '0;
      last_q      <= '0;
      sm_q        <= '0;
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      sm_q        <= sm_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        wi_q <= wi_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q != S_OUT) begin
      p_q <= prod;
    end
    if (accept) begin
      x_q <= in_sample_i;
    end
    if (state_q == S_RDT) begin
      tm_q <= $signed(ring_rdata_i);
    end
    if (state_q == S_YM) begin
      ym_q <= ym_val;
      tt_q <= $signed(ring_rdata_i);
    end
    if (state_q == S_YT) begin
      yt_q <= yt_val;
    end
    if (state_q == S_SM1 || state_q == S_ST1 || state_q == S_MX1 || state_q == S_WX1) begin
      acc_q <= p_wide;
    end
    if (out_load) begin
      out_q <= o_val;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

endmodule : fdly_core
`default_nettype wire

>>> sv/two_tap_feedback_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_tap_feedback_delay
// Fixed-point feedback delay with two lowpassed taps, tap crossfade and
// wet/dry blend.
//
// Usage:
//   Samples enter on in_valid_i/in_ready_o/in_sample_i and leave on
//   out_valid_o/out_ready_i/out_sample_o, one result per input transaction.
//   Writes on cfg_we_i/cfg_addr_i/cfg_wdata_i are taken at once; the user
//   must write only while no sample is in flight; the block does not check.
//   An accepted sample runs through S_FB to S_OUT; out_valid_o rises when
//   its result is loaded into the output register, and new samples are
//   taken only in S_IDLE. A single shared multiplier steps through 11
//   products per sample; one ring port serves the write and both tap reads.
//   Reset: registers take their default values, filter and feedback state
//   clear, and the ring is cleared one entry a cycle, from address 0 up to
//   RING_DEPTH-1; in_ready_o stays low until that is done.
//   Receiver stall: the finished sample waits in the output register; the
//   next sample is still accepted and processed, and it holds in its last
//   step until the output register is free.
// ----------------------------------------------------------------------------
module two_tap_feedback_delay
  import fdly_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]          cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_o
);

  localparam int ADDR_W = $clog2(RING_DEPTH);

  cfg_t              cfg_q;
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;

  logic                   core_we;
  logic [ADDR_W-1:0]      core_addr;
  logic [SAMPLE_BITS-1:0] core_wdata;
  logic                   ring_we;
  logic [ADDR_W-1:0]      ring_addr;
  logic [SAMPLE_BITS-1:0] ring_wdata;
  logic [SAMPLE_BITS-1:0] ring_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_TOTAL_DELAY:   cfg_q.total_delay   <= cfg_wdata_i[DELAY_W-1:0];
        REG_TAP_DELAY:     cfg_q.tap_delay     <= cfg_wdata_i[DELAY_W-1:0];
        REG_FEEDBACK_GAIN: cfg_q.feedback_gain <= cfg_wdata_i[GAIN_W-1:0];
        REG_WET_DRY:       cfg_q.wet_dry       <= cfg_wdata_i[GAIN_W-1:0];
        REG_TAP_MIX:       cfg_q.tap_mix       <= cfg_wdata_i[GAIN_W-1:0];
        REG_COEF_B0:       cfg_q.coef_b0       <= $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_COEF_B1:       cfg_q.coef_b1       <= $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_COEF_A1:       cfg_q.coef_a1       <= $signed(cfg_wdata_i[COEF_W-1:0]);
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  // sweep zeros through the ring after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(RING_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign ring_we    = clr_busy_q ? 1'b1 : core_we;
  assign ring_addr  = clr_busy_q ? clr_addr_q : core_addr;
  assign ring_wdata = clr_busy_q ? '0 : core_wdata;

  fdly_ring #(
    .DEPTH  (RING_DEPTH),
    .DATA_W (SAMPLE_BITS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .addr_i  (ring_addr),
    .wdata_i (ring_wdata),
    .rdata_o (ring_rdata)
  );

  fdly_core #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .run_i        (!clr_busy_q),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_sample_i  (in_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_sample_o (out_sample_o),
    .ring_we_o    (core_we),
    .ring_addr_o  (core_addr),
    .ring_wdata_o (core_wdata),
    .ring_rdata_i (ring_rdata)
  );

endmodule : two_tap_feedback_delay
`default_nettype wire
